FILE: design/ffbta_pkg.sv
// shared types, codes and command/status bundles for the first-fit boundary-tag allocator
`default_nettype none

package ffbta_pkg;

    // fixed field widths
    localparam int ADDR_W      = 32;
    localparam int REQ_W       = 13;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_BASE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_SIZE = 1'b1;

    localparam logic [REQ_W-1:0] HEAP_SIZE_RESET = 13'd4096;

    // request beat
    typedef struct packed {
        logic              kind;
        logic [REQ_W-1:0]  request_size;
        logic [ADDR_W-1:0] free_address;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic [ADDR_W-1:0]   payload_address;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    // controller states
    typedef enum logic [3:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_ALLOC,
        CTL_TAKE,
        CTL_FCALC,
        CTL_FHDR,
        CTL_FNEXT,
        CTL_FWRITE,
        CTL_DONE
    } ctl_state_t;

    // header memory read address select
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_FREE,
        RD_NEXT
    } rd_sel_t;

    // header memory write select
    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_SPLIT,
        WR_TAKE,
        WR_UNLINK,
        WR_RELEASE
    } wr_sel_t;

    // current block offset select
    typedef enum logic [1:0] {
        OFF_HOLD,
        OFF_ZERO,
        OFF_FREE,
        OFF_NEXT
    } off_sel_t;

    // working block size select
    typedef enum logic [1:0] {
        SZ_HOLD,
        SZ_REQ,
        SZ_HDR,
        SZ_MERGE
    } size_sel_t;

    // controller to datapath
    typedef struct packed {
        logic                in_capture;
        rd_sel_t             rd_sel;
        wr_sel_t             wr_sel;
        off_sel_t            off_sel;
        size_sel_t           size_sel;
        logic                nxt_load;
        logic                clr_step;
        logic                res_load;
        logic                res_grant;
        logic [STATUS_W-1:0] res_status;
        logic                out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cfg_size_wr;
        logic clr_last;
        logic in_kind;
        logic free_in_range;
        logic hdr_valid;
        logic hdr_taken;
        logic fit;
        logic split;
        logic nxt_in_heap;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: design/ffbta_datapath.sv
// header memory, block walk arithmetic, config registers and result register
`default_nettype none

module ffbta_datapath #(
    parameter int HEAP_BYTES   = 4096,
    parameter int TAG_BYTES    = 8,
    parameter int FOOTER_BYTES = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    input  wire logic [ffbta_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ffbta_pkg::ADDR_W-1:0]        cfg_wdata,
    input  wire ffbta_pkg::in_item_t                 s_data,
    input  wire logic                                m_ready,
    input  wire ffbta_pkg::dp_cmd_t                  cmd,
    output ffbta_pkg::dp_status_t                    stat,
    output logic                                     m_valid,
    output ffbta_pkg::out_item_t                     m_data
);

    localparam int OFF_W = $clog2(HEAP_BYTES);
    localparam int AW    = ((OFF_W > ffbta_pkg::REQ_W) ? OFF_W : ffbta_pkg::REQ_W) + 2;
    localparam int ENT_W = OFF_W + 2;
    localparam int OVH   = TAG_BYTES + FOOTER_BYTES;

    localparam logic [AW-1:0]    OVH_A    = AW'(OVH);
    localparam logic [AW-1:0]    HEAP_A   = AW'(HEAP_BYTES);
    localparam logic [OFF_W-1:0] CLR_LAST = OFF_W'(HEAP_BYTES - 1);
    localparam logic [ffbta_pkg::ADDR_W-1:0] TAG_32 = ffbta_pkg::ADDR_W'(TAG_BYTES);

    // header entry: valid, payload size, taken
    logic [ENT_W-1:0] hdr_mem [HEAP_BYTES];
    logic [ENT_W-1:0] rdata_reg;

    logic [ffbta_pkg::ADDR_W-1:0] heap_base_reg, heap_base_next;
    logic [ffbta_pkg::REQ_W-1:0]  heap_size_reg, heap_size_next;
    logic [OFF_W-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [ffbta_pkg::REQ_W-1:0]  req_reg, req_next;
    logic [ffbta_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [OFF_W-1:0]             off_reg, off_next;
    logic [OFF_W-1:0]             nxt_reg, nxt_next;
    logic [OFF_W-1:0]             size_reg, size_next;
    logic [ffbta_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [ffbta_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    ffbta_pkg::out_item_t         out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    logic [AW-1:0]    eff;
    logic             hdr_valid;
    logic             hdr_taken;
    logic [OFF_W-1:0] hdr_size;
    logic [AW-1:0]    hdr_size_a;
    logic [AW-1:0]    off_a;
    logic [AW-1:0]    req_a;
    logic [AW-1:0]    nxt_a;
    logic [AW-1:0]    second_a;
    logic [AW-1:0]    merge_size;
    logic [ffbta_pkg::ADDR_W-1:0] free_off;
    logic             free_in_range;
    logic             nxt_in_heap;
    logic             cfg_size_wr;
    logic [ENT_W-1:0] init_entry;
    logic [OFF_W-1:0] rd_addr;
    logic [OFF_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             wr_en;

    // managed size and header fields
    always_comb begin
        eff        = (AW'(heap_size_reg) > HEAP_A) ? HEAP_A : AW'(heap_size_reg);
        hdr_valid  = rdata_reg[ENT_W-1];
        hdr_size   = rdata_reg[OFF_W:1];
        hdr_taken  = rdata_reg[0];
        hdr_size_a = AW'(hdr_size);
        off_a      = AW'(off_reg);
        req_a      = AW'(req_reg);
        nxt_a      = off_a + hdr_size_a + OVH_A;
        second_a   = off_a + req_a + OVH_A;
        merge_size = AW'(size_reg) + OVH_A + hdr_size_a;
        nxt_in_heap   = nxt_a < eff;
        free_off      = addr_reg - heap_base_reg - TAG_32;
        free_in_range = free_off < ffbta_pkg::ADDR_W'(eff);
        cfg_size_wr   = cfg_valid && (cfg_index == ffbta_pkg::CFG_HEAP_SIZE);
        init_entry    = {eff >= OVH_A, OFF_W'(eff - OVH_A), 1'b0};
    end

    // status toward the controller
    always_comb begin
        stat.cfg_size_wr   = cfg_size_wr;
        stat.clr_last      = clr_cnt_reg == CLR_LAST;
        stat.in_kind       = s_data.kind;
        stat.free_in_range = free_in_range;
        stat.hdr_valid     = hdr_valid;
        stat.hdr_taken     = hdr_taken;
        stat.fit           = !hdr_taken && (hdr_size_a >= req_a);
        stat.split         = hdr_size_a > (req_a + OVH_A);
        stat.nxt_in_heap   = nxt_in_heap;
        stat.out_free      = !out_valid_reg || m_ready;
    end

    // read address decode
    always_comb begin
        unique case (cmd.rd_sel)
            ffbta_pkg::RD_FREE: rd_addr = free_in_range ? free_off[OFF_W-1:0] : '0;
            ffbta_pkg::RD_NEXT: rd_addr = nxt_in_heap ? nxt_a[OFF_W-1:0] : '0;
            default:            rd_addr = '0;
        endcase
    end

    // write port decode
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '0;
        unique case (cmd.wr_sel)
            ffbta_pkg::WR_CLEAR: begin
                wr_addr = clr_cnt_reg;
                wr_data = (clr_cnt_reg == '0) ? init_entry : '0;
            end
            ffbta_pkg::WR_SPLIT: begin
                wr_addr = second_a[OFF_W-1:0];
                wr_data = {1'b1, OFF_W'(hdr_size_a - req_a - OVH_A), 1'b0};
            end
            ffbta_pkg::WR_TAKE: begin
                wr_addr = off_reg;
                wr_data = {1'b1, size_reg, 1'b1};
            end
            ffbta_pkg::WR_UNLINK: begin
                wr_addr = nxt_reg;
                wr_data = '0;
            end
            ffbta_pkg::WR_RELEASE: begin
                wr_addr = off_reg;
                wr_data = {1'b1, size_reg, 1'b0};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // header memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hdr_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= hdr_mem[rd_addr];
    end

    // next values of the working registers
    always_comb begin
        heap_base_next = heap_base_reg;
        heap_size_next = heap_size_reg;
        if (cfg_valid && (cfg_index == ffbta_pkg::CFG_HEAP_BASE)) begin
            heap_base_next = cfg_wdata;
        end
        if (cfg_size_wr) begin
            heap_size_next = cfg_wdata[ffbta_pkg::REQ_W-1:0];
        end

        // clearing sweep counter, restarted by a size write
        clr_cnt_next = clr_cnt_reg;
        if (cfg_size_wr) begin
            clr_cnt_next = '0;
        end else if (cmd.clr_step) begin
            clr_cnt_next = (clr_cnt_reg == CLR_LAST) ? '0 : clr_cnt_reg + 1'b1;
        end

        req_next  = cmd.in_capture ? s_data.request_size : req_reg;
        addr_next = cmd.in_capture ? s_data.free_address : addr_reg;
        nxt_next  = cmd.nxt_load ? nxt_a[OFF_W-1:0] : nxt_reg;

        case (cmd.off_sel)
            ffbta_pkg::OFF_ZERO: off_next = '0;
            ffbta_pkg::OFF_FREE: off_next = free_off[OFF_W-1:0];
            ffbta_pkg::OFF_NEXT: off_next = nxt_a[OFF_W-1:0];
            default:             off_next = off_reg;
        endcase

        case (cmd.size_sel)
            ffbta_pkg::SZ_REQ:   size_next = OFF_W'(req_reg);
            ffbta_pkg::SZ_HDR:   size_next = hdr_size;
            ffbta_pkg::SZ_MERGE: size_next = OFF_W'(merge_size);
            default:             size_next = size_reg;
        endcase

        // pending result
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        if (cmd.res_load) begin
            res_status_next = cmd.res_status;
            res_addr_next   = cmd.res_grant
                ? heap_base_reg + ffbta_pkg::ADDR_W'(off_reg) + TAG_32 : '0;
        end

        // output register
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (cmd.out_load) begin
            out_next.payload_address = res_addr_reg;
            out_next.status          = res_status_reg;
            out_valid_next           = 1'b1;
        end
    end

    // control and config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
            heap_size_reg <= ffbta_pkg::HEAP_SIZE_RESET;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            heap_base_reg <= heap_base_next;
            heap_size_reg <= heap_size_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        off_reg        <= off_next;
        nxt_reg        <= nxt_next;
        size_reg       <= size_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

FILE: design/ffbta_ctrl.sv
// controller state machine sequencing clear, allocate walk and free
`default_nettype none

module ffbta_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire ffbta_pkg::dp_status_t  stat,
    output ffbta_pkg::dp_cmd_t          cmd
);

    ffbta_pkg::ctl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffbta_pkg::CTL_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ffbta_pkg::CTL_CLEAR: begin
                cmd.wr_sel   = ffbta_pkg::WR_CLEAR;
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ffbta_pkg::CTL_IDLE;
                end
            end
            ffbta_pkg::CTL_IDLE: begin
                s_ready = !stat.cfg_size_wr;
                if (s_valid && !stat.cfg_size_wr) begin
                    cmd.in_capture = 1'b1;
                    if (stat.in_kind == ffbta_pkg::KIND_ALLOC) begin
                        cmd.off_sel = ffbta_pkg::OFF_ZERO;
                        cmd.rd_sel  = ffbta_pkg::RD_ZERO;
                        state_next  = ffbta_pkg::CTL_ALLOC;
                    end else begin
                        state_next  = ffbta_pkg::CTL_FCALC;
                    end
                end
            end
            // one header per cycle: fit, step to the next block, or give up
            ffbta_pkg::CTL_ALLOC: begin
                if (!stat.hdr_valid) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ffbta_pkg::STATUS_NO_FIT;
                    state_next     = ffbta_pkg::CTL_DONE;
                end else if (stat.fit) begin
                    if (stat.split) begin
                        cmd.wr_sel   = ffbta_pkg::WR_SPLIT;
                        cmd.size_sel = ffbta_pkg::SZ_REQ;
                    end else begin
                        cmd.size_sel = ffbta_pkg::SZ_HDR;
                    end
                    state_next = ffbta_pkg::CTL_TAKE;
                end else if (stat.nxt_in_heap) begin
                    cmd.off_sel = ffbta_pkg::OFF_NEXT;
                    cmd.rd_sel  = ffbta_pkg::RD_NEXT;
                end else begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ffbta_pkg::STATUS_NO_FIT;
                    state_next     = ffbta_pkg::CTL_DONE;
                end
            end
            ffbta_pkg::CTL_TAKE: begin
                cmd.wr_sel     = ffbta_pkg::WR_TAKE;
                cmd.res_load   = 1'b1;
                cmd.res_grant  = 1'b1;
                cmd.res_status = ffbta_pkg::STATUS_OK;
                state_next     = ffbta_pkg::CTL_DONE;
            end
            ffbta_pkg::CTL_FCALC: begin
                if (stat.free_in_range) begin
                    cmd.off_sel = ffbta_pkg::OFF_FREE;
                    cmd.rd_sel  = ffbta_pkg::RD_FREE;
                    state_next  = ffbta_pkg::CTL_FHDR;
                end else begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ffbta_pkg::STATUS_BAD_FREE;
                    state_next     = ffbta_pkg::CTL_DONE;
                end
            end
            ffbta_pkg::CTL_FHDR: begin
                if (!stat.hdr_valid) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ffbta_pkg::STATUS_BAD_FREE;
                    state_next     = ffbta_pkg::CTL_DONE;
                end else begin
                    cmd.size_sel = ffbta_pkg::SZ_HDR;
                    cmd.nxt_load = 1'b1;
                    if (stat.nxt_in_heap) begin
                        cmd.rd_sel = ffbta_pkg::RD_NEXT;
                        state_next = ffbta_pkg::CTL_FNEXT;
                    end else begin
                        state_next = ffbta_pkg::CTL_FWRITE;
                    end
                end
            end
            // absorb a free successor
            ffbta_pkg::CTL_FNEXT: begin
                if (stat.hdr_valid && !stat.hdr_taken) begin
                    cmd.wr_sel   = ffbta_pkg::WR_UNLINK;
                    cmd.size_sel = ffbta_pkg::SZ_MERGE;
                end
                state_next = ffbta_pkg::CTL_FWRITE;
            end
            ffbta_pkg::CTL_FWRITE: begin
                cmd.wr_sel     = ffbta_pkg::WR_RELEASE;
                cmd.res_load   = 1'b1;
                cmd.res_status = ffbta_pkg::STATUS_OK;
                state_next     = ffbta_pkg::CTL_DONE;
            end
            ffbta_pkg::CTL_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ffbta_pkg::CTL_IDLE;
                end
            end
            default: begin
                state_next = ffbta_pkg::CTL_CLEAR;
            end
        endcase
        // a heap size write rebuilds the region
        if (stat.cfg_size_wr) begin
            state_next = ffbta_pkg::CTL_CLEAR;
        end
    end

endmodule

`default_nettype wire

FILE: design/first_fit_boundary_tag_allocator.sv
// First-fit heap allocator with boundary-tag block headers.
// Requests arrive on the s_ channel (allocate or free), one result beat per
// request leaves on the m_ channel; both use valid/ready. Configuration
// writes (heap_base, heap_size) go over the cfg_ channel, which is always
// ready. Block headers live in one HEAP_BYTES-deep memory with a single
// write port and one registered read port.
// Allocate: the walk reads one header per cycle from offset zero until a
// block fits (its header is then written taken) or the chain ends.
// Free: offset check, header read, successor read, header write, result;
// the successor read is skipped for the last block, and a bad address
// ends after the offset check or the header read.
// One request is in work at a time; the next is accepted once the result
// has moved to the output register. A stalled receiver holds that register;
// the block keeps accepting and finishes the next request, holding its
// result until the output register frees.
// Reset and every heap_size write clear all HEAP_BYTES header entries with
// s_ready low, leaving one free block if the region can hold one.
`default_nettype none

module first_fit_boundary_tag_allocator #(
    parameter int HEAP_BYTES   = 4096,
    parameter int TAG_BYTES    = 8,
    parameter int FOOTER_BYTES = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ffbta_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ffbta_pkg::ADDR_W-1:0]       cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire ffbta_pkg::in_item_t                s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output ffbta_pkg::out_item_t                    m_data
);

    ffbta_pkg::dp_cmd_t    cmd;
    ffbta_pkg::dp_status_t stat;

    assign cfg_ready = 1'b1;

    // sequencing
    ffbta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // header store and arithmetic
    ffbta_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .TAG_BYTES    (TAG_BYTES),
        .FOOTER_BYTES (FOOTER_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    // no request is taken in the cycle after reset
    a_reset_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request accepted right after reset");

    // a heap size write starts the clearing pass
    a_size_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && (cfg_index == ffbta_pkg::CFG_HEAP_SIZE) |=> !s_ready)
        else $error("request port open after heap size write");

    // one request at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while one is in work");

    // a result carries a defined status
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ffbta_pkg::STATUS_OK)
                 || (m_data.status == ffbta_pkg::STATUS_NO_FIT)
                 || (m_data.status == ffbta_pkg::STATUS_BAD_FREE))
        else $error("undefined result status");

    // failures carry address zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ffbta_pkg::STATUS_OK) |-> m_data.payload_address == '0)
        else $error("failed result with nonzero address");

endmodule

`default_nettype wire

FILE: tb/heap_result_checker.sv
// result checker for the first-fit allocator: shadow heap, expected results and comparison
module heap_result_checker #(
    parameter int HEAP_BYTES   = 4096,
    parameter int TAG_BYTES    = 8,
    parameter int FOOTER_BYTES = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [ffbta_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ffbta_pkg::ADDR_W-1:0]           cfg_wdata,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  ffbta_pkg::in_item_t                    s_data,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  ffbta_pkg::out_item_t                   m_data,
    output int                                     fail_count,
    output int                                     pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffbta_pkg::*;

    localparam int unsigned OVERHEAD = TAG_BYTES + FOOTER_BYTES;

    // shadow copy of the configuration and the block chain
    logic [ADDR_W-1:0] shadow_base;
    logic [REQ_W-1:0]  shadow_size;
    logic [13:0]       shadow_tag [HEAP_BYTES];
    bit                shadow_live [HEAP_BYTES];

    out_item_t   owed_results [$];
    int unsigned beat_no;

    initial begin
        fail_count = 0;
        pending    = 0;
        beat_no    = 0;
    end

    function automatic int unsigned usable_bytes();
        return (shadow_size > HEAP_BYTES) ? HEAP_BYTES : shadow_size;
    endfunction

    task automatic place_tag(input int unsigned off, input int unsigned payload,
                             input logic taken);
        shadow_tag[off]  = 14'((payload << 1) | taken);
        shadow_live[off] = 1'b1;
    endtask

    // one free block over the whole managed region, or nothing if too small
    task automatic rebuild_heap();
        int unsigned eff;
        eff = usable_bytes();
        for (int i = 0; i < HEAP_BYTES; i++) begin
            shadow_tag[i]  = '0;
            shadow_live[i] = 1'b0;
        end
        if (eff >= OVERHEAD)
            place_tag(0, eff - OVERHEAD, 1'b0);
    endtask

    task automatic report(input string what, input logic [ADDR_W-1:0] got,
                          input logic [ADDR_W-1:0] want);
        if (fail_count < 30)
            $display("[%0t] beat %0d: %s: got %h, expected %h", $realtime, beat_no, what,
                     got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        out_item_t     res;
        out_item_t     owed;
        int unsigned   eff, off, bsize, want, nxt;
        logic [ADDR_W-1:0] rel;
        bit            hit;

        if (!aresetn) begin
            shadow_base = '0;
            shadow_size = HEAP_SIZE_RESET;
            rebuild_heap();
            owed_results.delete();
        end else begin
            // compare the result beat against the oldest expectation
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    report("result beat with nothing outstanding", m_data.payload_address, '0);
                end else begin
                    owed = owed_results.pop_front();
                    if (m_data.payload_address !== owed.payload_address)
                        report("payload_address", m_data.payload_address,
                               owed.payload_address);
                    if (m_data.status !== owed.status)
                        report("status", ADDR_W'(m_data.status), ADDR_W'(owed.status));
                end
                beat_no++;
            end

            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_HEAP_BASE) begin
                    shadow_base = cfg_wdata;
                end else begin
                    shadow_size = cfg_wdata[REQ_W-1:0];
                    rebuild_heap();
                end
            end

            // predict the result of an accepted request beat
            if (s_valid && s_ready) begin
                eff = usable_bytes();
                res.payload_address = '0;
                if (s_data.kind == KIND_ALLOC) begin
                    // first-fit walk from offset zero
                    want = s_data.request_size;
                    off  = 0;
                    hit  = 1'b0;
                    res.status = STATUS_NO_FIT;
                    while (!hit && off < eff && shadow_live[off]) begin
                        bsize = shadow_tag[off] >> 1;
                        if (!shadow_tag[off][0] && bsize >= want) begin
                            // split only when the leftover can hold a whole block
                            if (bsize > want && bsize - want > OVERHEAD) begin
                                place_tag(off + want + OVERHEAD, bsize - want - OVERHEAD,
                                          1'b0);
                                bsize = want;
                            end
                            place_tag(off, bsize, 1'b1);
                            res.payload_address = shadow_base + off + TAG_BYTES;
                            res.status = STATUS_OK;
                            hit = 1'b1;
                        end else begin
                            off += bsize + OVERHEAD;
                        end
                    end
                end else begin
                    // release, merging with a free successor only
                    rel = s_data.free_address - shadow_base - TAG_BYTES;
                    if (rel >= eff || !shadow_live[rel]) begin
                        res.status = STATUS_BAD_FREE;
                    end else begin
                        off   = rel;
                        bsize = shadow_tag[off] >> 1;
                        nxt   = off + bsize + OVERHEAD;
                        if (nxt < eff && shadow_live[nxt] && !shadow_tag[nxt][0]) begin
                            bsize = (nxt - off) + (shadow_tag[nxt] >> 1);
                            shadow_live[nxt] = 1'b0;
                            shadow_tag[nxt]  = '0;
                        end
                        place_tag(off, bsize, 1'b0);
                        res.status = STATUS_OK;
                    end
                end
                owed_results.push_back(res);
            end
        end
        pending = owed_results.size();
    end

endmodule

FILE: tb/first_fit_boundary_tag_allocator_tb.sv
// top of the allocator testbench: clock, reset, request and register stimulus, verdict
module first_fit_boundary_tag_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffbta_pkg::*;

    localparam int HEAP_BYTES   = 4096;
    localparam int TAG_BYTES    = 8;
    localparam int FOOTER_BYTES = 8;
    localparam int CYCLE_LIMIT  = 1500000;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]      cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    int                     fail_count;
    int                     pending;

    // stimulus bookkeeping: offsets of blocks believed taken, and recently released
    logic [ADDR_W-1:0] cur_base;
    bit                steady;
    int unsigned       live_offs [$];
    int unsigned       freed_offs [$];
    logic              kinds_in_flight [$];
    int unsigned       cycles;

    first_fit_boundary_tag_allocator #(
        .HEAP_BYTES   (HEAP_BYTES),
        .TAG_BYTES    (TAG_BYTES),
        .FOOTER_BYTES (FOOTER_BYTES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    heap_result_checker #(
        .HEAP_BYTES   (HEAP_BYTES),
        .TAG_BYTES    (TAG_BYTES),
        .FOOTER_BYTES (FOOTER_BYTES)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // receiver: random wait per beat, two long holds to back the block up
    initial begin
        int unsigned rx_wait;
        int unsigned hold_left;
        int unsigned beats;
        rx_wait   = 0;
        hold_left = 0;
        beats     = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                beats++;
                rx_wait = steady ? 0 : $urandom_range(0, 7);
                if (beats == 50 || beats == 480)
                    hold_left = 400;
            end
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // track granted offsets so later frees can hit real blocks
    always @(posedge aclk) begin
        logic done_kind;
        if (aresetn) begin
            if (m_valid && m_ready && kinds_in_flight.size() > 0) begin
                done_kind = kinds_in_flight.pop_front();
                if (done_kind == KIND_ALLOC && m_data.status == STATUS_OK)
                    live_offs.push_back(m_data.payload_address - cur_base - TAG_BYTES);
            end
            if (s_valid && s_ready)
                kinds_in_flight.push_back(s_data.kind);
        end
    end

    // one request beat, after a random gap
    task automatic offer(input logic kind, input logic [REQ_W-1:0] want,
                         input logic [ADDR_W-1:0] addr);
        in_item_t    beat;
        int unsigned gap;
        beat.kind         = kind;
        beat.request_size = want;
        beat.free_address = addr;
        gap = steady ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_HEAP_BASE) begin
            cur_base = value;
        end else begin
            // region rebuilt, old blocks are gone
            live_offs.delete();
            freed_offs.delete();
        end
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    // mostly frees of live blocks and small allocations, some double and stray frees
    task automatic run_random(input int count, input bit calm);
        int unsigned       pick, idx, off, span;
        logic [ADDR_W-1:0] addr;
        logic [REQ_W-1:0]  want;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                steady = calm || ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            want = REQ_W'($urandom_range(0, 4096));
            addr = $urandom();
            if (pick < 40 && live_offs.size() > 0) begin
                idx = $urandom_range(0, live_offs.size() - 1);
                off = live_offs[idx];
                live_offs.delete(idx);
                freed_offs.push_back(off);
                if (freed_offs.size() > 16)
                    void'(freed_offs.pop_front());
                offer(KIND_FREE, want, cur_base + TAG_BYTES + off);
            end else if (pick < 46 && freed_offs.size() > 0) begin
                off = freed_offs[$urandom_range(0, freed_offs.size() - 1)];
                offer(KIND_FREE, want, cur_base + TAG_BYTES + off);
            end else if (pick < 52) begin
                if ($urandom_range(0, 1) == 1)
                    addr = cur_base + TAG_BYTES + $urandom_range(0, 4200);
                offer(KIND_FREE, want, addr);
            end else begin
                pick = $urandom_range(0, 99);
                span = (pick < 70) ? 48 : (pick < 90) ? 400 : (pick < 97) ? 2000 : 4096;
                want = REQ_W'($urandom_range(0, span));
                offer(KIND_ALLOC, want, addr);
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HEAP_BASE;
        cfg_wdata = '0;
        cur_base  = '0;
        steady    = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset heap: whole-region grant, no fit, double free, stray frees,
        // splits, exact fit without split, merge, last block
        offer(KIND_ALLOC, REQ_W'(HEAP_BYTES - TAG_BYTES - FOOTER_BYTES), '0);
        offer(KIND_ALLOC, '0, '0);
        offer(KIND_FREE, '0, 32'd8);
        offer(KIND_FREE, '0, 32'd8);
        offer(KIND_FREE, '0, 32'd9);
        offer(KIND_FREE, '0, 32'd0);
        offer(KIND_FREE, '1, 32'hFFFF_FFFF);
        offer(KIND_ALLOC, '0, '0);
        offer(KIND_ALLOC, 13'd100, '0);
        offer(KIND_ALLOC, 13'd4096, '0);
        offer(KIND_ALLOC, 13'd3940, '0);
        offer(KIND_FREE, '0, 32'd24);
        offer(KIND_FREE, '0, 32'd8);
        offer(KIND_ALLOC, 13'd116, '0);
        offer(KIND_FREE, '0, 32'd140);
        offer(KIND_ALLOC, 13'd4096, '1);
        run_random(200, 1'b0);
        drain();

        // base moved under live blocks, addresses wrap
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF0);
        run_random(60, 1'b0);
        drain();

        // a 32-byte region at the top base
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_HEAP_SIZE, 32'd32);
        offer(KIND_ALLOC, 13'd16, '0);
        offer(KIND_FREE, '0, 32'd7);
        offer(KIND_ALLOC, '0, '0);
        offer(KIND_FREE, '0, 32'd7);
        run_random(30, 1'b0);
        drain();

        // oversized region clamps to the full heap, no idling
        write_reg(CFG_HEAP_BASE, $urandom());
        write_reg(CFG_HEAP_SIZE, 32'd8191);
        run_random(120, 1'b1);
        drain();

        // region too small for any block
        write_reg(CFG_HEAP_SIZE, 32'd0);
        offer(KIND_ALLOC, '0, '0);
        offer(KIND_FREE, '0, cur_base + TAG_BYTES);
        run_random(10, 1'b0);
        drain();
        write_reg(CFG_HEAP_SIZE, 32'd15);
        run_random(5, 1'b0);
        drain();

        // region holding exactly one empty block
        write_reg(CFG_HEAP_SIZE, 32'd16);
        offer(KIND_ALLOC, '0, '0);
        offer(KIND_ALLOC, '0, '0);
        run_random(10, 1'b0);
        drain();

        write_reg(CFG_HEAP_BASE, 32'd0);
        write_reg(CFG_HEAP_SIZE, 32'd1000);
        run_random(150, 1'b0);
        drain();

        write_reg(CFG_HEAP_BASE, 32'h8000_0000);
        write_reg(CFG_HEAP_SIZE, 32'd4096);
        run_random(80, 1'b0);
        drain();

        repeat (300) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
